FILE: sv/gifp_pkg.sv
// Package: phases, record kinds, error codes and byte constants of the GIF parser.
`timescale 1ns / 1ps
`default_nettype none
package gifp_pkg;

    typedef enum logic [3:0] {
        PH_HEADER   = 4'd0,
        PH_SCREEN   = 4'd1,
        PH_GTABLE   = 4'd2,
        PH_BLOCK    = 4'd3,
        PH_EXTTYPE  = 4'd4,
        PH_CONTROL  = 4'd5,
        PH_APP      = 4'd6,
        PH_SKIPSIZE = 4'd7,
        PH_SKIPDATA = 4'd8,
        PH_IMAGE    = 4'd9,
        PH_LTABLE   = 4'd10,
        PH_MINCODE  = 4'd11,
        PH_DATASIZE = 4'd12,
        PH_DATASKIP = 4'd13,
        PH_STOPPED  = 4'd14
    } phase_t;

    localparam logic [2:0] KIND_SCREEN  = 3'd0;
    localparam logic [2:0] KIND_CONTROL = 3'd1;
    localparam logic [2:0] KIND_LOOP    = 3'd2;
    localparam logic [2:0] KIND_FRAME   = 3'd3;
    localparam logic [2:0] KIND_DATA    = 3'd4;
    localparam logic [2:0] KIND_DONE    = 3'd5;
    localparam logic [2:0] KIND_ERROR   = 3'd6;

    localparam logic [4:0] ERR_PAST_BUFFER   = 5'd0;
    localparam logic [4:0] ERR_NOT_GIF       = 5'd1;
    localparam logic [4:0] ERR_NOT_89A       = 5'd2;
    localparam logic [4:0] ERR_CTRL_SIZE     = 5'd3;
    localparam logic [4:0] ERR_CTRL_TERM     = 5'd4;
    localparam logic [4:0] ERR_DISPOSAL      = 5'd5;
    localparam logic [4:0] ERR_APP_SIZE      = 5'd6;
    localparam logic [4:0] ERR_APP_ID        = 5'd7;
    localparam logic [4:0] ERR_APP_AUTH      = 5'd8;
    localparam logic [4:0] ERR_LOOP_SIZE     = 5'd9;
    localparam logic [4:0] ERR_LOOP_ID       = 5'd10;
    localparam logic [4:0] ERR_LOOP_TERM     = 5'd11;
    localparam logic [4:0] ERR_CTRL_REPEAT   = 5'd12;
    localparam logic [4:0] ERR_UNKNOWN_EXT   = 5'd13;
    localparam logic [4:0] ERR_FRAME_SIZE    = 5'd14;
    localparam logic [4:0] ERR_FRAME_BOUNDS  = 5'd15;
    localparam logic [4:0] ERR_DATA_EMPTY    = 5'd16;
    localparam logic [4:0] ERR_NO_FRAME      = 5'd17;
    localparam logic [4:0] ERR_UNKNOWN_BLOCK = 5'd18;

    localparam logic [7:0] BYTE_EXT     = 8'h21;
    localparam logic [7:0] BYTE_IMAGE   = 8'h2C;
    localparam logic [7:0] BYTE_TRAILER = 8'h3B;
    localparam logic [7:0] EXT_CONTROL  = 8'hF9;
    localparam logic [7:0] EXT_APP      = 8'hFF;
    localparam logic [7:0] EXT_COMMENT  = 8'hFE;
    localparam logic [7:0] EXT_TEXT     = 8'h01;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [4:0]  error_code;
        logic [15:0] frame_number;
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic [15:0] third_word;
        logic [15:0] fourth_word;
        logic [7:0]  packed_flags;
        logic [7:0]  extra_byte;
        logic [31:0] image_bytes;
    } rec_t;

    // "GIF89a"
    function automatic logic [7:0] sig_char(input logic [2:0] k);
        logic [7:0] c;
        begin
            unique case (k)
                3'd0: c = 8'h47;
                3'd1: c = 8'h49;
                3'd2: c = 8'h46;
                3'd3: c = 8'h38;
                3'd4: c = 8'h39;
                3'd5: c = 8'h61;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // application identifier and auth code, 11 characters
    function automatic logic [7:0] app_char(input logic [3:0] k);
        logic [7:0] c;
        begin
            unique case (k)
                4'd0: c = 8'h4E;
                4'd1: c = 8'h45;
                4'd2: c = 8'h54;
                4'd3: c = 8'h53;
                4'd4: c = 8'h43;
                4'd5: c = 8'h41;
                4'd6: c = 8'h50;
                4'd7: c = 8'h45;
                4'd8: c = 8'h32;
                4'd9: c = 8'h2E;
                4'd10: c = 8'h30;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage
`default_nettype wire

FILE: sv/gif_container_stream_parser.sv
// Top level: stream ports, input register and result register around the parser core.
`timescale 1ns / 1ps
`default_nettype none
// Streaming GIF89a structure parser. One file byte per request on s_axis_*, tlast
// marking the buffer's last byte. Each byte is registered, decoded by one pass of
// compare logic and at most one record is registered on m_axis_*. One byte is
// accepted per clock while no record is held by m_axis_tready low; a record reaches
// the result register from the input register through the core's compare logic. A
// record held by m_axis_tready low stalls the input register.
// After an error or trailer, bytes are dropped up to tlast; the next byte starts a
// new file. LENGTH_BITS sets the saturation width of the frame data byte total.
module gif_container_stream_parser #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,  // [7:0] data_byte
    input  wire logic         s_axis_tlast,  // end_of_buffer
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [2:0] record_kind, [7:3] error_code, [23:8] frame_number, [39:24] first_word,
    // [55:40] second_word, [71:56] third_word, [87:72] fourth_word,
    // [95:88] packed_flags, [103:96] extra_byte, [135:104] image_bytes
    output logic [135:0]      m_axis_tdata
);
    import gifp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    rec_t       rec;
    logic       rec_valid;
    logic       out_valid_reg;
    rec_t       out_reg;
    logic       adv;

    // core step happens when the input stage is loaded and the result slot can take it
    assign adv = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    gifp_core #(.LENGTH_BITS(LENGTH_BITS)) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (adv),
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .rec       (rec),
        .rec_valid (rec_valid)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= rec_valid;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && rec_valid) out_reg <= rec;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {out_reg.image_bytes, out_reg.extra_byte, out_reg.packed_flags,
                           out_reg.fourth_word, out_reg.third_word, out_reg.second_word,
                           out_reg.first_word, out_reg.frame_number, out_reg.error_code,
                           out_reg.record_kind};
endmodule
`default_nettype wire

FILE: sv/gifp_core.sv
// Parser core: phase register, field collection and record generation for one byte.
`timescale 1ns / 1ps
`default_nettype none
module gifp_core #(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    output gifp_pkg::rec_t     rec,
    output logic               rec_valid
);
    import gifp_pkg::*;

    localparam int LB = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;
    localparam logic [LB-1:0] LEN_LIM = LB'((65'd1 << LENGTH_BITS) - 65'd1);

    phase_t        phase_reg, phase_next;
    logic [9:0]    count_reg, count_next;
    logic [63:0]   shift_reg, shift_next;
    logic [15:0]   cw_reg, cw_next, ch_reg, ch_next;
    logic [15:0]   frames_reg, frames_next;
    logic          seen_reg, seen_next;
    logic [7:0]    mincode_reg, mincode_next;
    logic [LB-1:0] total_reg, total_next;

    logic [15:0] w0, w1, w2, w3;
    logic [16:0] sum_x, sum_y;
    logic [15:0] img_h;
    logic [LB:0] total_sum;
    logic        stop;
    logic [4:0]  ecode;

    assign w0 = shift_reg[15:0];
    assign w1 = shift_reg[31:16];
    assign w2 = shift_reg[47:32];
    assign img_h = {in_byte, shift_reg[55:48]};
    assign w3 = shift_reg[63:48];
    assign sum_x = {1'b0, w2} + {1'b0, w0};
    assign sum_y = {1'b0, img_h} + {1'b0, w1};
    assign total_sum = {1'b0, total_reg} + {{LB-7{1'b0}}, in_byte};

    function automatic logic [9:0] tbytes(input logic [2:0] s);
        return 10'(11'd3 << ({1'b0, s} + 4'd1));
    endfunction

    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        shift_next   = shift_reg;
        cw_next      = cw_reg;
        ch_next      = ch_reg;
        frames_next  = frames_reg;
        seen_next    = seen_reg;
        mincode_next = mincode_reg;
        total_next   = total_reg;
        rec          = '0;
        rec_valid    = 1'b0;
        stop         = 1'b0;
        ecode        = ERR_PAST_BUFFER;

        unique case (phase_reg)
            PH_HEADER: begin
                if (count_reg >= 10'd6 || in_byte != sig_char(count_reg[2:0])) begin
                    stop = 1'b1;
                    ecode = (count_reg < 10'd3) ? ERR_NOT_GIF : ERR_NOT_89A;
                end else if (count_reg == 10'd5) begin
                    phase_next = PH_SCREEN;
                    count_next = '0;
                end else begin
                    count_next = count_reg + 10'd1;
                end
            end
            PH_SCREEN: begin
                if (count_reg < 10'd6) begin
                    shift_next[8*count_reg[2:0] +: 8] = in_byte;
                    count_next = count_reg + 10'd1;
                end else begin
                    cw_next = w0;
                    ch_next = w1;
                    rec_valid = 1'b1;
                    rec.record_kind = KIND_SCREEN;
                    rec.first_word = w0;
                    rec.second_word = w1;
                    rec.packed_flags = shift_reg[39:32];
                    rec.extra_byte = shift_reg[47:40];
                    shift_next = '0;
                    if (shift_reg[39]) begin
                        phase_next = PH_GTABLE;
                        count_next = tbytes(shift_reg[34:32]);
                    end else begin
                        phase_next = PH_BLOCK;
                        count_next = '0;
                    end
                end
            end
            PH_GTABLE, PH_LTABLE: begin
                if (count_reg > 10'd1) begin
                    count_next = count_reg - 10'd1;
                end else begin
                    phase_next = (phase_reg == PH_GTABLE) ? PH_BLOCK : PH_MINCODE;
                    count_next = '0;
                    shift_next = '0;
                end
            end
            PH_BLOCK: begin
                count_next = '0;
                shift_next = '0;
                priority if (in_byte == BYTE_EXT) begin
                    phase_next = PH_EXTTYPE;
                end else if (in_byte == BYTE_IMAGE) begin
                    phase_next = PH_IMAGE;
                    total_next = '0;
                end else if (in_byte == BYTE_TRAILER) begin
                    if (frames_reg == 16'd0) begin
                        stop = 1'b1;
                        ecode = ERR_NO_FRAME;
                    end else begin
                        phase_next = PH_STOPPED;
                        rec_valid = 1'b1;
                        rec.record_kind = KIND_DONE;
                    end
                end else begin
                    stop = 1'b1;
                    ecode = ERR_UNKNOWN_BLOCK;
                end
            end
            PH_EXTTYPE: begin
                priority if (in_byte == EXT_CONTROL) begin
                    if (seen_reg) begin
                        stop = 1'b1;
                        ecode = ERR_CTRL_REPEAT;
                    end else begin
                        seen_next = 1'b1;
                        phase_next = PH_CONTROL;
                    end
                end else if (in_byte == EXT_APP) begin
                    phase_next = PH_APP;
                end else if (in_byte == EXT_COMMENT || in_byte == EXT_TEXT) begin
                    phase_next = PH_SKIPSIZE;
                end else begin
                    stop = 1'b1;
                    ecode = ERR_UNKNOWN_EXT;
                end
            end
            PH_CONTROL: begin
                count_next = count_reg + 10'd1;
                priority if (count_reg == 10'd0) begin
                    if (in_byte != 8'd4) begin
                        stop = 1'b1;
                        ecode = ERR_CTRL_SIZE;
                    end
                end else if (count_reg == 10'd1) begin
                    if (in_byte[4:2] > 3'd3) begin
                        stop = 1'b1;
                        ecode = ERR_DISPOSAL;
                    end
                    shift_next[15:8] = in_byte;
                end else if (count_reg < 10'd5) begin
                    shift_next[8*count_reg[2:0] +: 8] = in_byte;
                end else begin
                    if (in_byte != 8'd0) begin
                        stop = 1'b1;
                        ecode = ERR_CTRL_TERM;
                    end else begin
                        rec_valid = 1'b1;
                        rec.record_kind = KIND_CONTROL;
                        rec.first_word = w1;
                        rec.packed_flags = shift_reg[15:8];
                        rec.extra_byte = shift_reg[39:32];
                        phase_next = PH_BLOCK;
                        count_next = '0;
                        shift_next = '0;
                    end
                end
            end
            PH_APP: begin
                count_next = count_reg + 10'd1;
                priority if (count_reg == 10'd0) begin
                    if (in_byte != 8'd11) begin
                        stop = 1'b1;
                        ecode = ERR_APP_SIZE;
                    end
                end else if (count_reg <= 10'd11) begin
                    if (in_byte != app_char(4'(count_reg - 10'd1))) begin
                        stop = 1'b1;
                        ecode = (count_reg <= 10'd8) ? ERR_APP_ID : ERR_APP_AUTH;
                    end
                end else if (count_reg == 10'd12) begin
                    if (in_byte != 8'd3) begin
                        stop = 1'b1;
                        ecode = ERR_LOOP_SIZE;
                    end
                end else if (count_reg == 10'd13) begin
                    if (in_byte != 8'd1) begin
                        stop = 1'b1;
                        ecode = ERR_LOOP_ID;
                    end
                end else if (count_reg < 10'd16) begin
                    shift_next[8*count_reg[0] +: 8] = in_byte;
                end else begin
                    if (in_byte != 8'd0) begin
                        stop = 1'b1;
                        ecode = ERR_LOOP_TERM;
                    end else begin
                        rec_valid = 1'b1;
                        rec.record_kind = KIND_LOOP;
                        rec.first_word = w0;
                        phase_next = PH_BLOCK;
                        count_next = '0;
                        shift_next = '0;
                    end
                end
            end
            PH_SKIPSIZE: begin
                if (in_byte == 8'd0) begin
                    phase_next = PH_BLOCK;
                    count_next = '0;
                    shift_next = '0;
                end else begin
                    phase_next = PH_SKIPDATA;
                    count_next = {2'b00, in_byte};
                end
            end
            PH_SKIPDATA, PH_DATASKIP: begin
                if (count_reg > 10'd1) count_next = count_reg - 10'd1;
                else phase_next = (phase_reg == PH_SKIPDATA) ? PH_SKIPSIZE : PH_DATASIZE;
            end
            PH_IMAGE: begin
                if (count_reg < 10'd8) begin
                    shift_next[8*count_reg[2:0] +: 8] = in_byte;
                    count_next = count_reg + 10'd1;
                    if (count_reg == 10'd7) begin
                        // size first, then canvas bounds
                        if (sum_x[16] || sum_y[16] || w2 == 16'd0 || img_h == 16'd0) begin
                            stop = 1'b1;
                            ecode = ERR_FRAME_SIZE;
                        end else if (sum_x[15:0] > cw_reg || sum_y[15:0] > ch_reg) begin
                            stop = 1'b1;
                            ecode = ERR_FRAME_BOUNDS;
                        end
                    end
                end else begin
                    rec_valid = 1'b1;
                    rec.record_kind = KIND_FRAME;
                    rec.first_word = w0;
                    rec.second_word = w1;
                    rec.third_word = w2;
                    rec.fourth_word = w3;
                    rec.packed_flags = in_byte;
                    shift_next = '0;
                    if (in_byte[7]) begin
                        phase_next = PH_LTABLE;
                        count_next = tbytes(in_byte[2:0]);
                    end else begin
                        phase_next = PH_MINCODE;
                        count_next = '0;
                    end
                end
            end
            PH_MINCODE: begin
                mincode_next = in_byte;
                phase_next = PH_DATASIZE;
                count_next = '0;
                shift_next = '0;
            end
            PH_DATASIZE: begin
                if (in_byte == 8'd0) begin
                    if (total_reg == '0) begin
                        stop = 1'b1;
                        ecode = ERR_DATA_EMPTY;
                    end else begin
                        rec_valid = 1'b1;
                        rec.record_kind = KIND_DATA;
                        rec.extra_byte = mincode_reg;
                        rec.image_bytes = (total_reg > LB'(32'hFFFF_FFFF))
                            ? 32'hFFFF_FFFF : total_reg[31:0];
                        if (frames_reg != 16'hFFFF) frames_next = frames_reg + 16'd1;
                        seen_next = 1'b0;
                        phase_next = PH_BLOCK;
                        count_next = '0;
                        shift_next = '0;
                    end
                end else begin
                    total_next = (total_sum > {1'b0, LEN_LIM}) ? LEN_LIM : total_sum[LB-1:0];
                    phase_next = PH_DATASKIP;
                    count_next = {2'b00, in_byte};
                end
            end
            PH_STOPPED: begin
            end
            default: begin
            end
        endcase

        if (stop) begin
            rec = '0;
            rec_valid = 1'b1;
            rec.record_kind = KIND_ERROR;
            rec.error_code = ecode;
            phase_next = PH_STOPPED;
            count_next = '0;
            shift_next = '0;
        end
        rec.frame_number = frames_reg;

        if (in_last) begin
            if (phase_next != PH_STOPPED) begin
                // frame count as left by this byte, a closing data record included
                rec = '0;
                rec_valid = 1'b1;
                rec.record_kind = KIND_ERROR;
                rec.error_code = ERR_PAST_BUFFER;
                rec.frame_number = frames_next;
            end
            phase_next   = PH_HEADER;
            count_next   = '0;
            shift_next   = '0;
            cw_next      = '0;
            ch_next      = '0;
            frames_next  = '0;
            seen_next    = 1'b0;
            mincode_next = '0;
            total_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEADER;
            count_reg   <= '0;
            shift_reg   <= '0;
            cw_reg      <= '0;
            ch_reg      <= '0;
            frames_reg  <= '0;
            seen_reg    <= 1'b0;
            mincode_reg <= '0;
            total_reg   <= '0;
        end else if (in_valid) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            shift_reg   <= shift_next;
            cw_reg      <= cw_next;
            ch_reg      <= ch_next;
            frames_reg  <= frames_next;
            seen_reg    <= seen_next;
            mincode_reg <= mincode_next;
            total_reg   <= total_next;
        end
    end
endmodule
`default_nettype wire
